>>> design/lcag_pkg.sv
// ----------------------------------------------------------------------------
// lcag_pkg: shared types and constants for the Game of Life grid
// Operation codes, sequencer states, the 3x3 neighbourhood window and the
// B3/S23 rule counts.
// ----------------------------------------------------------------------------
package lcag_pkg;

    localparam logic [1:0] FUNC_WRITE   = 2'd0;
    localparam logic [1:0] FUNC_READ    = 2'd1;
    localparam logic [1:0] FUNC_ADVANCE = 2'd2;

    localparam logic [1:0] CFG_GRID_ROWS = 2'd0;
    localparam logic [1:0] CFG_GRID_COLS = 2'd1;

    localparam logic [7:0] GRID_ROWS_RESET = 8'd100;
    localparam logic [7:0] GRID_COLS_RESET = 8'd100;

    // A live cell survives with 2 or 3 live neighbors; a dead cell is born with 3.
    localparam logic [3:0] SURVIVE_LOW = 4'd2;
    localparam logic [3:0] BIRTH_COUNT = 4'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_GEN_LOAD,
        ST_GEN_NEXT,
        ST_GEN_SWEEP,
        ST_GEN_WB
    } t_state;

    // Three columns of the row above, the cell's own row and the row below.
    // Bit 0 is the left neighbor column, bit 1 the center, bit 2 the right.
    typedef struct packed {
        logic [2:0] top;
        logic [2:0] mid;
        logic [2:0] bot;
    } t_window;

endpackage

>>> design/lcag_rule.sv
// ----------------------------------------------------------------------------
// lcag_rule: B3/S23 cell update
// Counts the eight neighbors of a 3x3 window and returns the next state of
// the center cell.
// ----------------------------------------------------------------------------
module lcag_rule (
    input  lcag_pkg::t_window i_win,
    output logic              o_alive
);
    import lcag_pkg::*;

    logic [3:0] w_count;
    logic       w_center;

    assign w_center = i_win.mid[1];

    assign w_count = 4'(i_win.top[0]) + 4'(i_win.top[1]) + 4'(i_win.top[2])
                   + 4'(i_win.mid[0]) + 4'(i_win.mid[2])
                   + 4'(i_win.bot[0]) + 4'(i_win.bot[1]) + 4'(i_win.bot[2]);

    always_comb begin
        if (w_center) begin
            o_alive = (w_count == SURVIVE_LOW) || (w_count == BIRTH_COUNT);
        end else begin
            o_alive = (w_count == BIRTH_COUNT);
        end
    end

endmodule

>>> design/life_cellular_automaton_grid.sv
// A cell write, an address error or an unused code gives its result in the
// cycle after the start beat; a cell read also passes through ST_READ.
// A generation is swept by the single cell rule unit, which visits one cell per
// cycle, with one row write per row.
// After reset the grid is cleared one row per cycle, all MAX_ROWS rows, with
// busy high. Results are one-cycle strobes; the receiver cannot stall.
// ----------------------------------------------------------------------------
// life_cellular_automaton_grid: Conway Game of Life grid, rule B3/S23
// Holds a bounded grid of one-bit cells in a row-wide memory. Cells are
// written, read, or advanced one generation with a three-row window and a
// shared cell rule unit.
// ----------------------------------------------------------------------------
module life_cellular_automaton_grid #(
    parameter int MAX_ROWS = 128,
    parameter int MAX_COLS = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic [1:0] i_func,
    input  logic [6:0] i_row,
    input  logic [6:0] i_col,
    input  logic       i_alive_in,
    output logic       o_done,
    output logic       o_alive_out,
    output logic       o_addr_error,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import lcag_pkg::*;

    localparam int RW   = $clog2(MAX_ROWS);
    localparam int CIW  = $clog2(MAX_COLS);
    localparam int RCW0 = $clog2(MAX_ROWS + 1);
    localparam int CCW0 = $clog2(MAX_COLS + 1);
    localparam int RCW  = (RCW0 > 8) ? RCW0 : 8;
    localparam int CCW  = (CCW0 > 8) ? CCW0 : 8;

    // Row store
    logic [MAX_COLS-1:0] mem [MAX_ROWS];
    logic                mem_we;
    logic [RW-1:0]       mem_waddr;
    logic [MAX_COLS-1:0] mem_wmask;
    logic [MAX_COLS-1:0] mem_wdata;
    logic [RW-1:0]       mem_raddr;
    logic [MAX_COLS-1:0] r_rd;

    t_state r_state, n_state;

    logic [7:0]          r_grid_rows, r_grid_cols;
    logic [RW-1:0]       r_clr_row, n_clr_row;
    logic [RCW-1:0]      r_row, n_row;
    logic [CIW-1:0]      r_col, n_col;
    logic [CIW-1:0]      r_op_col, n_op_col;
    logic [MAX_COLS-1:0] r_prev, n_prev;
    logic [MAX_COLS-1:0] r_cur, n_cur;
    logic [MAX_COLS-1:0] r_next, n_next;
    logic [MAX_COLS-1:0] r_new, n_new;
    logic                r_done, n_done;
    logic                r_alive_out, n_alive_out;
    logic                r_addr_error, n_addr_error;

    logic [RCW-1:0]      eff_rows;
    logic [CCW-1:0]      eff_cols;
    logic                accept;
    logic                addr_bad;
    logic                grid_empty;
    logic [RW+6:0]       row_wide;
    logic [CIW+6:0]      col_wide;
    logic [RW-1:0]       in_row_idx;
    logic [CIW-1:0]      in_col_idx;
    logic [RCW-1:0]      row_p1;
    logic [RCW-1:0]      row_p2;
    logic [CCW-1:0]      col_p1;
    logic [CIW-1:0]      col_lo, col_hi;
    logic                has_left, has_right, last_col, last_row;
    t_window             win;
    logic                cell_new;

    assign eff_rows = (RCW'(r_grid_rows) > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS)
                                                           : RCW'(r_grid_rows);
    assign eff_cols = (CCW'(r_grid_cols) > CCW'(MAX_COLS)) ? CCW'(MAX_COLS)
                                                           : CCW'(r_grid_cols);

    assign accept     = i_start && !o_busy;
    assign addr_bad   = (RCW'(i_row) >= eff_rows) || (CCW'(i_col) >= eff_cols);
    assign grid_empty = (eff_rows == '0) || (eff_cols == '0);
    assign row_wide   = {{RW{1'b0}}, i_row};
    assign col_wide   = {{CIW{1'b0}}, i_col};
    assign in_row_idx = row_wide[RW-1:0];
    assign in_col_idx = col_wide[CIW-1:0];

    assign row_p1    = r_row + RCW'(1);
    assign row_p2    = r_row + RCW'(2);
    assign col_p1    = CCW'(r_col) + CCW'(1);
    assign col_lo    = r_col - CIW'(1);
    assign col_hi    = r_col + CIW'(1);
    assign has_left  = (r_col != '0);
    assign has_right = (col_p1 < eff_cols);
    assign last_col  = (col_p1 == eff_cols);
    assign last_row  = (row_p1 == eff_rows);

    // Neighborhood of the current cell; columns past the area edges read as dead.
    always_comb begin
        win.top[1] = r_prev[r_col];
        win.mid[1] = r_cur[r_col];
        win.bot[1] = r_next[r_col];
        win.top[0] = has_left ? r_prev[col_lo] : 1'b0;
        win.mid[0] = has_left ? r_cur[col_lo]  : 1'b0;
        win.bot[0] = has_left ? r_next[col_lo] : 1'b0;
        win.top[2] = has_right ? r_prev[col_hi] : 1'b0;
        win.mid[2] = has_right ? r_cur[col_hi]  : 1'b0;
        win.bot[2] = has_right ? r_next[col_hi] : 1'b0;
    end

    lcag_rule u_rule (
        .i_win   (win),
        .o_alive (cell_new)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_row == RW'(MAX_ROWS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_func == FUNC_READ && !addr_bad) begin
                        n_state = ST_READ;
                    end else if (i_func == FUNC_ADVANCE && !grid_empty) begin
                        n_state = ST_GEN_LOAD;
                    end
                end
            end
            ST_READ:      n_state = ST_IDLE;
            ST_GEN_LOAD:  n_state = ST_GEN_NEXT;
            ST_GEN_NEXT:  n_state = ST_GEN_SWEEP;
            ST_GEN_SWEEP: begin
                if (last_col) begin
                    n_state = ST_GEN_WB;
                end
            end
            ST_GEN_WB: begin
                n_state = last_row ? ST_IDLE : ST_GEN_NEXT;
            end
            default:      n_state = ST_CLEAR;
        endcase
    end

    // Datapath and memory controls
    always_comb begin
        n_clr_row    = r_clr_row;
        n_row        = r_row;
        n_col        = r_col;
        n_op_col     = r_op_col;
        n_prev       = r_prev;
        n_cur        = r_cur;
        n_next       = r_next;
        n_new        = r_new;
        n_done       = 1'b0;
        n_alive_out  = 1'b0;
        n_addr_error = 1'b0;
        mem_we       = 1'b0;
        mem_waddr    = r_row[RW-1:0];
        mem_wmask    = '1;
        mem_wdata    = r_new;
        mem_raddr    = '0;
        case (r_state)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_row;
                mem_wdata = '0;
                n_clr_row = r_clr_row + RW'(1);
            end
            ST_IDLE: begin
                mem_raddr = in_row_idx;
                n_op_col  = in_col_idx;
                if (accept) begin
                    case (i_func)
                        FUNC_WRITE: begin
                            n_done       = 1'b1;
                            n_addr_error = addr_bad;
                            mem_we       = !addr_bad;
                            mem_waddr    = in_row_idx;
                            mem_wmask    = {{(MAX_COLS-1){1'b0}}, 1'b1} << in_col_idx;
                            mem_wdata    = {MAX_COLS{i_alive_in}};
                        end
                        FUNC_READ: begin
                            n_done       = addr_bad;
                            n_addr_error = addr_bad;
                        end
                        FUNC_ADVANCE: begin
                            mem_raddr = '0;
                            n_done    = grid_empty;
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                n_done      = 1'b1;
                n_alive_out = r_rd[r_op_col];
            end
            ST_GEN_LOAD: begin
                // Row 0 is in the read register; fetch row 1 behind it.
                n_prev    = '0;
                n_cur     = r_rd;
                n_new     = r_rd;
                n_row     = '0;
                mem_raddr = RW'(1);
            end
            ST_GEN_NEXT: begin
                n_next = (row_p1 < eff_rows) ? r_rd : '0;
                n_col  = '0;
            end
            ST_GEN_SWEEP: begin
                n_new[r_col] = cell_new;
                n_col        = r_col + CIW'(1);
            end
            ST_GEN_WB: begin
                // Store the finished row and fetch the row two below it while
                // the old copies of this row and the next one slide up.
                mem_we    = 1'b1;
                mem_raddr = row_p2[RW-1:0];
                n_prev    = r_cur;
                n_cur     = r_next;
                n_new     = r_next;
                n_row     = row_p1;
                n_done    = last_row;
            end
            default: begin
                n_clr_row = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            for (int i = 0; i < MAX_COLS; i++) begin
                if (mem_wmask[i]) begin
                    mem[mem_waddr][i] <= mem_wdata[i];
                end
            end
        end
        r_rd <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_row    <= '0;
            r_row        <= '0;
            r_col        <= '0;
            r_done       <= 1'b0;
            r_alive_out  <= 1'b0;
            r_addr_error <= 1'b0;
            r_grid_rows  <= GRID_ROWS_RESET;
            r_grid_cols  <= GRID_COLS_RESET;
        end else begin
            r_state      <= n_state;
            r_clr_row    <= n_clr_row;
            r_row        <= n_row;
            r_col        <= n_col;
            r_done       <= n_done;
            r_alive_out  <= n_alive_out;
            r_addr_error <= n_addr_error;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_GRID_ROWS) begin
                    r_grid_rows <= i_cfg_data;
                end else if (i_cfg_index == CFG_GRID_COLS) begin
                    r_grid_cols <= i_cfg_data;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_op_col <= n_op_col;
        r_prev   <= n_prev;
        r_cur    <= n_cur;
        r_next   <= n_next;
        r_new    <= n_new;
    end

    assign o_busy       = (r_state != ST_IDLE);
    assign o_cfg_ready  = 1'b1;
    assign o_done       = r_done;
    assign o_alive_out  = r_alive_out;
    assign o_addr_error = r_addr_error;

endmodule
